// File: rtl/ctwa_pkg.sv
// Shared types and constants for the client table with aging.
// Used by the front end, the operation queue, the engine and the top level.
package ctwa_pkg;

   localparam int CMD_W     = 3;
   localparam int ID_W      = 31;
   localparam int IDX_W     = 4;
   localparam int TICK_W    = 32;
   localparam int TIMEOUT_W = 16;
   localparam int STATUS_W  = 4;
   localparam int TOTAL_W   = 5;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd35;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [CMD_W-1:0] CMD_HEARD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SWEEP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

   typedef enum logic [2:0] {
      OP_HEARD,
      OP_FIND,
      OP_TICK,
      OP_SWEEP,
      OP_DELETE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED      = 4'd0,
      ST_REFRESHED  = 4'd1,
      ST_FULL       = 4'd2,
      ST_FOUND      = 4'd3,
      ST_NOT_FOUND  = 4'd4,
      ST_DELETED    = 4'd5,
      ST_BAD_INDEX  = 4'd6,
      ST_TIMED_OUT  = 4'd7,
      ST_SWEEP_DONE = 4'd8,
      ST_TICKED     = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_RESOLVE,
      S_SWEEP_READ,
      S_SWEEP_CHECK,
      S_GRAB,
      S_MOVE
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     client_id;
      logic [IDX_W-1:0]    entry_index;
   } op_entry_type;

endpackage

// File: rtl/client_table_with_aging_core.sv
// Top level of the client table with aging: timeout register and block wiring.
// Depends on ctwa_pkg, ctwa_front, ctwa_queue and ctwa_engine.
//
//   Port group   Direction  Handshake            Carries
//   req_*        in         req_valid/req_ready  cmd, client_id, entry_index
//   rsp_*        out        rsp_valid/rsp_ready  status, index, id, total, last
//   csr_*        in         csr_valid/csr_ready  timeout_ticks
//
// Heard and find scan the stored entries with one read of the id store per
// cycle. A sweep checks each stored entry and removes the expired ones.
// Reset is synchronous; the stores need no clearing pass after reset.
// A two-deep queue lets requests arrive while a response waits on rsp_ready.
module client_table_with_aging_core
   import ctwa_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [ID_W-1:0]       req_client_id,
   input  logic [IDX_W-1:0]      req_entry_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]      rsp_result_index,
   output logic [ID_W-1:0]       rsp_result_id,
   output logic [TOTAL_W-1:0]    rsp_entry_total,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TIMEOUT_W-1:0]  csr_timeout_ticks
);

   logic [TIMEOUT_W-1:0]  timeout_ff;
   logic [TIMEOUT_W-1:0]  timeout_in;
   logic                  push;
   op_entry_type          push_entry;
   logic                  q_full;
   logic                  q_valid;
   op_entry_type          q_head;
   logic                  q_pop;

   assign csr_ready  = 1'b1;
   assign timeout_in = (csr_valid && csr_ready) ? csr_timeout_ticks : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   ctwa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_client_id   (req_client_id),
      .req_entry_index (req_entry_index),
      .q_full          (q_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   ctwa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   ctwa_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .timeout_ticks    (timeout_ff),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_result_id    (rsp_result_id),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_last         (rsp_last)
   );

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("Request pushed into a full queue.");

   a_timeout_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_TIMED_OUT)) |-> !rsp_last)
      else $error("Timed-out response marked as last.");

   a_added_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ADDED))
         |-> (rsp_result_index == IDX_W'(rsp_entry_total - 5'd1)))
      else $error("Added entry is not the last slot of the table.");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("Engine popped an empty queue.");
`endif

endmodule

// File: rtl/ctwa_front.sv
// Request front end: decodes the command and drops unused codes.
// Depends on ctwa_pkg; feeds ctwa_queue.
module ctwa_front
   import ctwa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ID_W-1:0]     req_client_id,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic                q_full,
   output logic                push,
   output op_entry_type        push_entry
);

   logic   legal;
   op_type op;
   logic   seen_ff;
   logic   seen_in;

   always_comb begin
      legal = 1'b1;
      op    = OP_HEARD;
      unique case (req_cmd)
         CMD_HEARD:  op = OP_HEARD;
         CMD_FIND:   op = OP_FIND;
         CMD_TICK:   op = OP_TICK;
         CMD_SWEEP:  op = OP_SWEEP;
         CMD_DELETE: op = OP_DELETE;
         default:    legal = 1'b0;
      endcase
   end

   assign req_ready              = !q_full;
   assign push                   = req_valid && req_ready && legal;
   assign push_entry.op          = op;
   assign push_entry.client_id   = req_client_id;
   assign push_entry.entry_index = req_entry_index;

   // Tracks whether any request has been taken since reset.
   assign seen_in = seen_ff || (req_valid && req_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

// File: rtl/ctwa_queue.sv
// Short operation queue between the front end and the engine.
// Depends on ctwa_pkg for the entry type and depth.
module ctwa_queue
   import ctwa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  op_entry_type  push_entry,
   output logic          full,
   output logic          not_empty,
   output op_entry_type  head,
   input  logic          pop
);

   op_entry_type        slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     fill_ff;
   logic [QPTR_W:0]     fill_in;

   assign full      = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/ctwa_engine.sv
// Table engine: id and timestamp stores, tick counter, lookup, sweep and removal.
// Depends on ctwa_pkg; takes operations from ctwa_queue and drives the response register.
module ctwa_engine
   import ctwa_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TIMEOUT_W-1:0]  timeout_ticks,
   input  logic                  q_valid,
   input  op_entry_type          q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [IDX_W-1:0]      rsp_result_index,
   output logic [ID_W-1:0]       rsp_result_id,
   output logic [TOTAL_W-1:0]    rsp_entry_total,
   output logic                  rsp_last
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   logic [ID_W-1:0]    id_store_ff    [MAX_ENTRIES];
   logic [TICK_W-1:0]  heard_store_ff [MAX_ENTRIES];
   logic [ID_W-1:0]    rd_id_ff;
   logic [TICK_W-1:0]  rd_heard_ff;
   logic [IW-1:0]      rd_addr;
   logic [IW-1:0]      wr_addr;
   logic               wr_id_en;
   logic               wr_heard_en;
   logic [ID_W-1:0]    wr_id;
   logic [TICK_W-1:0]  wr_heard;

   state_type          state_ff, state_in;
   op_entry_type       cur_ff, cur_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [TICK_W-1:0]  now_ff, now_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_idx_ff, pend_idx_in;
   logic [CW-1:0]      slot_ff, slot_in;
   logic               hit_ff, hit_in;
   logic [ID_W-1:0]    gone_ff, gone_in;

   logic               rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]   rsp_index_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               emit;
   status_type         e_status;
   logic [IDX_W-1:0]   e_index;
   logic [ID_W-1:0]    e_id;
   logic [CW-1:0]      e_total;
   logic               e_last;

   logic [IW-1:0]      last_slot;
   logic [TICK_W-1:0]  age;
   logic               expired;
   logic               index_ok;
   logic               table_full;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign last_slot  = IW'(count_ff - CW'(1));
   assign age        = now_ff - rd_heard_ff;
   assign expired    = (age >= TICK_W'(timeout_ticks));
   assign index_ok   = (XW'(cur_ff.entry_index) < XW'(count_ff));
   assign table_full = (count_ff == CW'(MAX_ENTRIES));

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      count_in    = count_ff;
      now_in      = now_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      slot_in     = slot_ff;
      hit_in      = hit_ff;
      gone_in     = gone_ff;
      q_pop       = 1'b0;
      rd_addr     = '0;
      wr_addr     = slot_ff[IW-1:0];
      wr_id_en    = 1'b0;
      wr_heard_en = 1'b0;
      wr_id       = rd_id_ff;
      wr_heard    = rd_heard_ff;
      emit        = 1'b0;
      e_status    = ST_TICKED;
      e_index     = '0;
      e_id        = '0;
      e_total     = count_ff;
      e_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            unique case (cur_ff.op)
               OP_HEARD, OP_FIND: begin
                  scan_in  = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCAN;
               end
               OP_TICK: begin
                  if (out_free) begin
                     now_in   = now_ff + TICK_W'(1);
                     emit     = 1'b1;
                     e_status = ST_TICKED;
                     state_in = S_IDLE;
                  end
               end
               OP_SWEEP: begin
                  slot_in  = '0;
                  state_in = S_SWEEP_READ;
               end
               OP_DELETE: begin
                  if (index_ok) begin
                     rd_addr  = IW'(cur_ff.entry_index);
                     slot_in  = CW'(cur_ff.entry_index);
                     state_in = S_GRAB;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     e_status = ST_BAD_INDEX;
                     e_index  = cur_ff.entry_index;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_SCAN: begin
            if (pend_ff && (rd_id_ff == cur_ff.client_id)) begin
               hit_in   = 1'b1;
               slot_in  = CW'(pend_idx_ff);
               state_in = S_RESOLVE;
            end else if (scan_ff < count_ff) begin
               rd_addr     = scan_ff[IW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[IW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else begin
               hit_in   = 1'b0;
               state_in = S_RESOLVE;
            end
         end

         S_RESOLVE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_id     = cur_ff.client_id;
               state_in = S_IDLE;
               if (cur_ff.op == OP_FIND) begin
                  e_status = hit_ff ? ST_FOUND : ST_NOT_FOUND;
                  e_index  = hit_ff ? IDX_W'(slot_ff) : '0;
               end else if (hit_ff) begin
                  wr_heard_en = 1'b1;
                  wr_heard    = now_ff;
                  e_status    = ST_REFRESHED;
                  e_index     = IDX_W'(slot_ff);
               end else if (table_full) begin
                  e_status = ST_FULL;
               end else begin
                  wr_addr     = count_ff[IW-1:0];
                  wr_id_en    = 1'b1;
                  wr_heard_en = 1'b1;
                  wr_id       = cur_ff.client_id;
                  wr_heard    = now_ff;
                  count_in    = count_ff + CW'(1);
                  e_status    = ST_ADDED;
                  e_index     = IDX_W'(count_ff);
                  e_total     = count_ff + CW'(1);
               end
            end
         end

         S_SWEEP_READ: begin
            if (slot_ff < count_ff) begin
               rd_addr  = slot_ff[IW-1:0];
               state_in = S_SWEEP_CHECK;
            end else if (out_free) begin
               emit     = 1'b1;
               e_status = ST_SWEEP_DONE;
               state_in = S_IDLE;
            end
         end

         S_SWEEP_CHECK: begin
            if (expired) begin
               gone_in  = rd_id_ff;
               rd_addr  = last_slot;
               state_in = S_MOVE;
            end else begin
               slot_in  = slot_ff + CW'(1);
               state_in = S_SWEEP_READ;
            end
         end

         S_GRAB: begin
            gone_in  = rd_id_ff;
            rd_addr  = last_slot;
            state_in = S_MOVE;
         end

         S_MOVE: begin
            rd_addr = last_slot;
            if (out_free) begin
               wr_id_en    = 1'b1;
               wr_heard_en = 1'b1;
               count_in    = count_ff - CW'(1);
               emit        = 1'b1;
               e_index     = IDX_W'(slot_ff);
               e_id        = gone_ff;
               e_total     = count_ff - CW'(1);
               if (cur_ff.op == OP_SWEEP) begin
                  e_status = ST_TIMED_OUT;
                  e_last   = 1'b0;
                  state_in = S_SWEEP_READ;
               end else begin
                  e_status = ST_DELETED;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         now_ff   <= now_in;
         pend_ff  <= pend_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      hit_ff      <= hit_in;
      gone_ff     <= gone_in;
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_index_ff  <= e_index;
         rsp_id_ff     <= e_id;
         rsp_total_ff  <= TOTAL_W'(e_total);
         rsp_last_ff   <= e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_id_en) begin
         id_store_ff[wr_addr] <= wr_id;
      end
      if (wr_heard_en) begin
         heard_store_ff[wr_addr] <= wr_heard;
      end
      rd_id_ff    <= id_store_ff[rd_addr];
      rd_heard_ff <= heard_store_ff[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_entry_total  = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
